@@ src/ba_pkg.sv @@
// Package with the shared constants, types and seed function of the buddy allocator.
`default_nettype none
package ba_pkg;

    localparam int POOL_UNITS = 1024;
    localparam int UNIT_BYTES = 16;
    localparam int ADDR_W     = $clog2(POOL_UNITS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int ORD_W      = 4;
    localparam int BYTE_W     = 15;
    localparam int SHIFT_B    = $clog2(UNIT_BYTES);

    typedef struct packed {
        logic             start;
        logic             free;
        logic [ORD_W-1:0] order;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_STATUS = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_A_RD,
        ST_A_EV,
        ST_SPLIT,
        ST_F_RD,
        ST_F_EV,
        ST_M_RD,
        ST_M_EV,
        ST_DONE
    } state_t;

    // Entry written at an address by the seeding pass for a given pool size.
    function automatic entry_t seed_entry(input logic [ADDR_W-1:0] a,
                                          input logic [CNT_W-1:0] pool);
        entry_t           e;
        logic [CNT_W-1:0] aw;
        logic [CNT_W-1:0] lowmask;
        e  = '0;
        aw = CNT_W'(a);
        for (int k = 0; k < CNT_W; k++) begin
            lowmask = CNT_W'((12'(1) << (k + 1)) - 12'(1));
            if (pool[k] && ((aw & lowmask) == '0) && ((aw & ~lowmask) == (pool & ~lowmask))) begin
                e.start = 1'b1;
                e.free  = 1'b1;
                e.order = ORD_W'(k);
            end
        end
        return e;
    endfunction

endpackage
`default_nettype wire

@@ src/ba_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none
module ba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ src/buddy_allocator.sv @@
// Buddy allocator top level: block table in RAM walked and updated by a small sequencer.
// One transaction at a time; s_tready stays low until the result has been taken.
// An allocate walks the blocks in order and splits the one it finds; a free reads its block and then
// merges with its buddy for as long as the buddy is a free block of the same order; status reads no table.
// Early rejections, a free of a non-block address and a failed walk also end in a result.
// Synchronous active-low reset gives a free 1024-unit pool; each reseed rewrites every table entry.
`default_nettype none
module buddy_allocator (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // request_bytes[15:0], free_addr[26:16], zero fill
    input  wire logic [1:0]  s_tuser,   // opcode[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // ok[0], user_addr[11:1], granted_units[22:12], total_bytes[37:23],
    // bytes_in_use[52:38], available_bytes[67:53], zero fill
    output logic [71:0]      m_tdata
);

    localparam int AW = ba_pkg::ADDR_W;
    localparam int CW = ba_pkg::CNT_W;
    localparam int OW = ba_pkg::ORD_W;
    localparam int BW = ba_pkg::BYTE_W;

    ba_pkg::state_t state_reg, state_next;
    logic [AW-1:0]  sweep_reg, sweep_next;
    logic [CW-1:0]  pool_reg, pool_next;
    logic [CW-1:0]  s_reg, s_next;
    logic [OW-1:0]  o_reg, o_next;
    logic [OW-1:0]  ord_reg, ord_next;
    logic [BW-1:0]  alloc_reg, alloc_next;
    logic           ok_reg, ok_next;
    logic [CW-1:0]  uaddr_reg, uaddr_next;
    logic [CW-1:0]  units_reg, units_next;
    logic           m_valid_reg, m_valid_next;
    logic [71:0]    m_data_reg, m_data_next;

    logic               we;
    logic [AW-1:0]      waddr, raddr;
    ba_pkg::entry_t     wdata, rentry;
    logic [ba_pkg::ENTRY_W-1:0] rdata;

    logic [CW-1:0] eff;
    logic [11:0]   len;
    logic [11:0]   bud;
    logic [16:0]   ceil_sum;
    logic [12:0]   ceil_units;
    logic [OW-1:0] need_ord;
    logic [13:0]   need_req;
    logic [CW-1:0] req_size;
    logic [15:0]   add_sum;
    logic [BW-1:0] sub_bytes;
    logic [BW-1:0] tot_bytes;
    logic [BW-1:0] avail_bytes;
    logic [15:0]   req_bytes;
    logic [CW-1:0] free_addr;
    logic [CW-1:0] free_s;

    assign eff         = (pool_reg > CW'(ba_pkg::POOL_UNITS)) ? CW'(ba_pkg::POOL_UNITS) : pool_reg;
    assign rentry      = ba_pkg::entry_t'(rdata);
    assign len         = 12'(1) << o_reg;
    assign bud         = 12'(s_reg) ^ len;
    assign req_bytes   = s_tdata[15:0];
    assign free_addr   = s_tdata[26:16];
    assign free_s      = free_addr - CW'(1);
    assign ceil_sum    = 17'(req_bytes) + 17'(ba_pkg::UNIT_BYTES - 1);
    assign ceil_units  = ceil_sum[16:ba_pkg::SHIFT_B];
    assign need_req    = 14'(1) << need_ord;
    assign req_size    = CW'(12'(1) << ord_reg);
    assign add_sum     = 16'(alloc_reg) + (16'(req_size) << ba_pkg::SHIFT_B);
    assign sub_bytes   = BW'(units_reg) << ba_pkg::SHIFT_B;
    assign tot_bytes   = BW'(eff) << ba_pkg::SHIFT_B;
    assign avail_bytes = (tot_bytes >= alloc_reg) ? tot_bytes - alloc_reg : '0;

    always_comb begin
        need_ord = '0;
        for (int i = 0; i < 13; i++) begin
            if (ceil_units[i]) begin
                need_ord = OW'(i + 1);
            end
        end
    end

    ba_ram #(
        .WIDTH(ba_pkg::ENTRY_W),
        .DEPTH(ba_pkg::POOL_UNITS)
    ) u_table (
        .aclk (aclk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign s_tready = (state_reg == ba_pkg::ST_IDLE) && !m_valid_reg;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ba_pkg::ST_SWEEP;
            sweep_reg   <= '0;
            pool_reg    <= CW'(ba_pkg::POOL_UNITS);
            alloc_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            sweep_reg   <= sweep_next;
            pool_reg    <= pool_next;
            alloc_reg   <= alloc_next;
            m_valid_reg <= m_valid_next;
        end
        s_reg      <= s_next;
        o_reg      <= o_next;
        ord_reg    <= ord_next;
        ok_reg     <= ok_next;
        uaddr_reg  <= uaddr_next;
        units_reg  <= units_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        pool_next    = pool_reg;
        alloc_next   = alloc_reg;
        m_valid_next = m_valid_reg;
        s_next       = s_reg;
        o_next       = o_reg;
        ord_next     = ord_reg;
        ok_next      = ok_reg;
        uaddr_next   = uaddr_reg;
        units_next   = units_reg;
        m_data_next  = m_data_reg;
        we           = 1'b0;
        waddr        = s_reg[AW-1:0];
        wdata        = '0;
        raddr        = s_reg[AW-1:0];

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ba_pkg::ST_SWEEP: begin
                we         = 1'b1;
                waddr      = sweep_reg;
                wdata      = ba_pkg::seed_entry(sweep_reg, eff);
                sweep_next = sweep_reg + AW'(1);
                alloc_next = '0;
                if (sweep_reg == '1) begin
                    state_next = ba_pkg::ST_IDLE;
                end
            end
            ba_pkg::ST_IDLE: begin
                ok_next    = 1'b0;
                uaddr_next = '0;
                units_next = '0;
                if (s_tvalid && s_tready) begin
                    state_next = ba_pkg::ST_DONE;
                    unique case (ba_pkg::opcode_t'(s_tuser))
                        ba_pkg::OP_ALLOC: begin
                            ord_next = need_ord;
                            s_next   = '0;
                            if (req_bytes != '0 && need_ord <= OW'(AW)
                                && need_req <= 14'(eff)) begin
                                state_next = ba_pkg::ST_A_RD;
                            end
                        end
                        ba_pkg::OP_FREE: begin
                            s_next = free_s;
                            if (free_addr != '0 && free_s < eff) begin
                                state_next = ba_pkg::ST_F_RD;
                            end
                        end
                        ba_pkg::OP_STATUS: begin
                            ok_next = 1'b1;
                        end
                        ba_pkg::OP_NONE: begin
                            ok_next = 1'b0;
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            ba_pkg::ST_A_RD: begin
                if (s_reg >= eff) begin
                    state_next = ba_pkg::ST_DONE;
                end else begin
                    state_next = ba_pkg::ST_A_EV;
                end
            end
            ba_pkg::ST_A_EV: begin
                if (rentry.free && rentry.order >= ord_reg) begin
                    o_next     = rentry.order;
                    state_next = ba_pkg::ST_SPLIT;
                end else begin
                    s_next     = CW'(12'(s_reg) + (12'(1) << rentry.order));
                    state_next = ba_pkg::ST_A_RD;
                end
            end
            ba_pkg::ST_SPLIT: begin
                we = 1'b1;
                if (o_reg > ord_reg) begin
                    o_next      = o_reg - OW'(1);
                    waddr       = AW'(12'(s_reg) + (12'(1) << (o_reg - OW'(1))));
                    wdata.start = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.order = o_reg - OW'(1);
                end else begin
                    wdata.start = 1'b1;
                    wdata.free  = 1'b0;
                    wdata.order = ord_reg;
                    alloc_next  = add_sum[BW] ? '1 : add_sum[BW-1:0];
                    ok_next     = 1'b1;
                    uaddr_next  = s_reg + CW'(1);
                    units_next  = req_size;
                    state_next  = ba_pkg::ST_DONE;
                end
            end
            ba_pkg::ST_F_RD: begin
                state_next = ba_pkg::ST_F_EV;
            end
            ba_pkg::ST_F_EV: begin
                if (!rentry.start || rentry.free) begin
                    state_next = ba_pkg::ST_DONE;
                end else begin
                    o_next     = rentry.order;
                    units_next = CW'(12'(1) << rentry.order);
                    ok_next    = 1'b1;
                    state_next = ba_pkg::ST_M_RD;
                end
            end
            ba_pkg::ST_M_RD: begin
                raddr = bud[AW-1:0];
                if (bud >= 12'(eff) || (bud + len) > 12'(eff)) begin
                    we          = 1'b1;
                    wdata.start = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.order = o_reg;
                    alloc_next  = (alloc_reg >= sub_bytes) ? alloc_reg - sub_bytes : '0;
                    state_next  = ba_pkg::ST_DONE;
                end else begin
                    state_next = ba_pkg::ST_M_EV;
                end
            end
            ba_pkg::ST_M_EV: begin
                we = 1'b1;
                if (rentry.start && rentry.free && rentry.order == o_reg) begin
                    waddr      = AW'(12'(s_reg) | len);
                    s_next     = CW'(12'(s_reg) & ~len);
                    o_next     = o_reg + OW'(1);
                    state_next = ba_pkg::ST_M_RD;
                end else begin
                    wdata.start = 1'b1;
                    wdata.free  = 1'b1;
                    wdata.order = o_reg;
                    alloc_next  = (alloc_reg >= sub_bytes) ? alloc_reg - sub_bytes : '0;
                    state_next  = ba_pkg::ST_DONE;
                end
            end
            ba_pkg::ST_DONE: begin
                m_data_next  = {4'b0, avail_bytes, alloc_reg, tot_bytes,
                                units_reg, uaddr_reg, ok_reg};
                m_valid_next = 1'b1;
                state_next   = ba_pkg::ST_IDLE;
            end
            default: begin
                state_next = ba_pkg::ST_IDLE;
            end
        endcase

        if (cfg_wr_en) begin
            pool_next    = cfg_wr_data;
            sweep_next   = '0;
            state_next   = ba_pkg::ST_SWEEP;
        end
    end

endmodule
`default_nettype wire

@@ tb/buddy_allocator_check.sv @@
// Checker that mirrors the buddy allocator, predicts each result and compares it on the master side.
module buddy_allocator_check (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [10:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic [1:0]  s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [71:0] m_tdata,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic        ok;
        logic [10:0] user_addr;
        logic [10:0] granted_units;
        logic [14:0] total_bytes;
        logic [14:0] bytes_in_use;
        logic [14:0] available_bytes;
    } answer_t;

    logic [3:0]  blk_order [ba_pkg::POOL_UNITS];
    logic        blk_start [ba_pkg::POOL_UNITS];
    logic        blk_free  [ba_pkg::POOL_UNITS];
    int unsigned held_bytes;
    int unsigned pool_size;
    answer_t     answers [$];

    function automatic int unsigned usable_units();
        return pool_size > ba_pkg::POOL_UNITS ? ba_pkg::POOL_UNITS : pool_size;
    endfunction

    function automatic void carve_pool(input logic [10:0] units);
        int unsigned left;
        int unsigned cur;
        int unsigned ord;
        pool_size = units;
        left = usable_units();
        cur = 0;
        held_bytes = 0;
        for (int i = 0; i < ba_pkg::POOL_UNITS; i++) begin
            blk_order[i] = '0;
            blk_start[i] = 1'b0;
            blk_free[i]  = 1'b0;
        end
        while (left > 0 && cur < ba_pkg::POOL_UNITS) begin
            ord = 0;
            while ((1 << (ord + 1)) <= left) ord++;
            blk_order[cur] = 4'(ord);
            blk_start[cur] = 1'b1;
            blk_free[cur]  = 1'b1;
            cur  += 1 << ord;
            left -= 1 << ord;
        end
    endfunction

    function automatic bit grant_block(input int unsigned bytes, output int unsigned addr,
                                       output int unsigned units);
        int unsigned need;
        int unsigned ord;
        int unsigned req;
        int unsigned o;
        int unsigned b;
        addr = 0;
        units = 0;
        if (bytes == 0) return 1'b0;
        need = (bytes + ba_pkg::UNIT_BYTES - 1) / ba_pkg::UNIT_BYTES + 1;
        ord = 0;
        while ((1 << ord) < need) ord++;
        req = 1 << ord;
        if (req > usable_units()) return 1'b0;
        for (int unsigned s = 0; s < usable_units(); s++) begin
            if (blk_start[s] && blk_free[s] && (1 << blk_order[s]) >= req) begin
                while (blk_order[s] > ord) begin
                    o = blk_order[s] - 1;
                    b = s + (1 << o);
                    blk_order[s] = 4'(o);
                    if (b < ba_pkg::POOL_UNITS) begin
                        blk_order[b] = 4'(o);
                        blk_start[b] = 1'b1;
                        blk_free[b]  = 1'b1;
                    end
                end
                blk_free[s] = 1'b0;
                held_bytes += req * ba_pkg::UNIT_BYTES;
                if (held_bytes > 32767) held_bytes = 32767;
                addr  = s + 1;
                units = req;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit release_block(input int unsigned uaddr, output int unsigned units);
        int unsigned s;
        int unsigned bytes;
        int unsigned o;
        int unsigned len;
        int unsigned bud;
        int unsigned lo;
        int unsigned hi;
        units = 0;
        if (uaddr == 0) return 1'b0;
        s = uaddr - 1;
        if (s >= usable_units() || !blk_start[s] || blk_free[s]) return 1'b0;
        units = 1 << blk_order[s];
        bytes = units * ba_pkg::UNIT_BYTES;
        held_bytes = held_bytes >= bytes ? held_bytes - bytes : 0;
        blk_free[s] = 1'b1;
        forever begin
            o   = blk_order[s];
            len = 1 << o;
            bud = s ^ len;
            if (bud >= usable_units() || bud + len > usable_units()) break;
            if (!blk_start[bud] || !blk_free[bud] || blk_order[bud] != o) break;
            lo = s < bud ? s : bud;
            hi = s < bud ? bud : s;
            blk_start[hi] = 1'b0;
            blk_free[hi]  = 1'b0;
            blk_order[hi] = '0;
            blk_order[lo] = 4'(o + 1);
            blk_free[lo]  = 1'b1;
            s = lo;
        end
        return 1'b1;
    endfunction

    function automatic answer_t predict_answer(input ba_pkg::opcode_t op,
                                               input logic [15:0] bytes,
                                               input logic [10:0] uaddr);
        answer_t     a;
        int unsigned addr;
        int unsigned units;
        int unsigned tot;
        a = '0;
        addr = 0;
        units = 0;
        case (op)
            ba_pkg::OP_ALLOC: begin
                a.ok = grant_block(bytes, addr, units);
            end
            ba_pkg::OP_FREE: begin
                a.ok = release_block(uaddr, units);
            end
            ba_pkg::OP_STATUS: begin
                a.ok = 1'b1;
            end
            default: begin
                a.ok = 1'b0;
            end
        endcase
        tot = (usable_units() * ba_pkg::UNIT_BYTES) & 32'h7FFF;
        a.user_addr       = 11'(addr);
        a.granted_units   = 11'(units);
        a.total_bytes     = 15'(tot);
        a.bytes_in_use    = 15'(held_bytes);
        a.available_bytes = tot >= held_bytes ? 15'(tot - held_bytes) : '0;
        return a;
    endfunction

    task automatic report(input string what, input int unsigned got, input int unsigned want);
        $display("mismatch at %0t: %s is %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
    end

    always @(posedge aclk) begin
        answer_t want;
        if (!aresetn) begin
            carve_pool(11'd1024);
            answers.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (answers.size() == 0) begin
                    report("unexpected transaction, ok", m_tdata[0], 0);
                end else begin
                    want = answers.pop_front();
                    if (m_tdata[0] !== want.ok)
                        report("ok", m_tdata[0], want.ok);
                    if (m_tdata[11:1] !== want.user_addr)
                        report("user_addr", m_tdata[11:1], want.user_addr);
                    if (m_tdata[22:12] !== want.granted_units)
                        report("granted_units", m_tdata[22:12], want.granted_units);
                    if (m_tdata[37:23] !== want.total_bytes)
                        report("total_bytes", m_tdata[37:23], want.total_bytes);
                    if (m_tdata[52:38] !== want.bytes_in_use)
                        report("bytes_in_use", m_tdata[52:38], want.bytes_in_use);
                    if (m_tdata[67:53] !== want.available_bytes)
                        report("available_bytes", m_tdata[67:53], want.available_bytes);
                end
            end
            if (s_tvalid && s_tready)
                answers.push_back(predict_answer(ba_pkg::opcode_t'(s_tuser), s_tdata[15:0],
                                                 s_tdata[26:16]));
            if (cfg_wr_en) carve_pool(cfg_wr_data);
        end
        pending <= answers.size();
    end

endmodule

@@ tb/buddy_allocator_test.sv @@
// Testbench top for the buddy allocator: clock, reset, stimulus, receiver stalls and verdict.
module buddy_allocator_test;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [10:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    int          fail_count;
    int          pending;

    logic [10:0] live_addrs [$];
    logic [10:0] last_freed;
    int          burst_left;

    buddy_allocator u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    buddy_allocator_check u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .pending     (pending)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Granted addresses are collected so that most frees name a live block.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready && m_tdata[0] && m_tdata[11:1] != 0)
            live_addrs.push_back(m_tdata[11:1]);
    end

    task automatic offer_request(input ba_pkg::opcode_t op, input logic [15:0] bytes,
                                 input logic [10:0] uaddr);
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {5'b0, uaddr, bytes};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid = 1'b0;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = $urandom_range(0, 15);
        end
    endtask

    task automatic free_live(input logic [15:0] bytes);
        int          k;
        logic [10:0] a;
        k = $urandom_range(0, live_addrs.size() - 1);
        a = live_addrs[k];
        live_addrs.delete(k);
        last_freed = a;
        offer_request(ba_pkg::OP_FREE, bytes, a);
    endtask

    task automatic random_request();
        int          pick;
        int          sz;
        logic [15:0] junk;
        pick = $urandom_range(0, 99);
        junk = 16'($urandom);
        if (pick < 45) begin
            sz = $urandom_range(0, 99);
            if (sz < 70)
                offer_request(ba_pkg::OP_ALLOC, 16'($urandom_range(1, 100)), 11'($urandom));
            else if (sz < 90)
                offer_request(ba_pkg::OP_ALLOC, 16'($urandom_range(101, 2000)), 11'($urandom));
            else if (sz < 98)
                offer_request(ba_pkg::OP_ALLOC, 16'($urandom_range(2001, 16368)),
                              11'($urandom));
            else offer_request(ba_pkg::OP_ALLOC, junk, 11'($urandom));
        end else if (pick < 82 && live_addrs.size() > 0) begin
            free_live(junk);
        end else if (pick < 88) begin
            offer_request(ba_pkg::OP_FREE, junk, 11'($urandom_range(0, 2047)));
        end else if (pick < 92) begin
            offer_request(ba_pkg::OP_FREE, junk, last_freed);
        end else if (pick < 97) begin
            offer_request(ba_pkg::OP_STATUS, junk, 11'($urandom));
        end else begin
            offer_request(ba_pkg::OP_NONE, junk, 11'($urandom));
        end
    endtask

    task automatic write_pool(input logic [10:0] units);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = units;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        live_addrs.delete();
    endtask

    initial begin
        logic [10:0] pool_steps [6];
        int          guard;
        pool_steps = '{11'd0, 11'd1, 11'd2047, 11'd1000, 11'd37, 11'd1024};
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = ba_pkg::OP_STATUS;
        last_freed  = '0;
        burst_left  = 0;
        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        offer_request(ba_pkg::OP_STATUS, 16'hFFFF, 11'h7FF);
        offer_request(ba_pkg::OP_ALLOC, 16'd0, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'hFFFF, 11'h7FF);
        offer_request(ba_pkg::OP_ALLOC, 16'd16369, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'd1, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'd16, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'd17, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'd8176, 11'd0);
        offer_request(ba_pkg::OP_ALLOC, 16'd8177, 11'd0);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd0);
        offer_request(ba_pkg::OP_FREE, 16'hFFFF, 11'h7FF);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd1025);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd1);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd1);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd3);
        offer_request(ba_pkg::OP_NONE, 16'hFFFF, 11'h7FF);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd5);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd513);
        offer_request(ba_pkg::OP_ALLOC, 16'd16368, 11'd0);
        offer_request(ba_pkg::OP_FREE, 16'd0, 11'd1);
        offer_request(ba_pkg::OP_STATUS, 16'd0, 11'd0);
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge aclk);
        live_addrs.delete();

        for (int p = 0; p <= 6; p++) begin
            if (p > 0) write_pool(pool_steps[p - 1]);
            repeat (190) random_request();
        end
        s_tvalid = 1'b0;

        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (50) @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // The receiver stalls on its own pattern, with one long hold-off early in the run.
    initial begin
        int mode;
        int len;
        m_tready = 1'b0;
        repeat (2200) @(negedge aclk) m_tready = $urandom_range(0, 3) != 0;
        m_tready = 1'b0;
        repeat (3000) @(negedge aclk);
        forever begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(1, 40);
            repeat (len) begin
                @(negedge aclk);
                m_tready = mode == 0 ? 1'b1 : mode == 1 ? ($urandom_range(0, 3) != 0)
                                                        : 1'($urandom_range(0, 1));
            end
        end
    end

    initial begin
        #200000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
src/ba_pkg.sv
src/ba_ram.sv
src/buddy_allocator.sv
tb/buddy_allocator_check.sv
tb/buddy_allocator_test.sv
